// ===== rtl/rgbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbs_pkg
// Shared types, codes and helpers of the RGB565 image blit scaler: draw modes,
// register indexes, header positions, controller states and the
// control/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rgbs_pkg;

    localparam int FIELD_BITS     = 16;
    localparam int BYTE_BITS      = 8;
    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_INDEX_BITS = 3;

    // floor(v / 3) for v below 64 as (v * 171) >> 9
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_X   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_Y   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_MODE = 3'd4;

    localparam logic [2:0] HP_BYTE0     = 3'd0;
    localparam logic [2:0] HP_WIDTH_HI  = 3'd2;
    localparam logic [2:0] HP_WIDTH_LO  = 3'd3;
    localparam logic [2:0] HP_HEIGHT_HI = 3'd4;
    localparam logic [2:0] HP_HEIGHT_LO = 3'd5;
    localparam logic [2:0] HP_PIXELS    = 3'd6;
    localparam logic [2:0] HP_DONE      = 3'd7;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_SCALED = 2'd1,
        MODE_DIM    = 2'd2,
        MODE_OFF    = 2'd3
    } draw_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X_GO,
        ST_DIV_X_WAIT,
        ST_DIV_Y_WAIT,
        ST_EMIT
    } rgbs_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_y;
        logic save_x;
        logic load_out;
    } rgbs_cmd_t;

    typedef struct packed {
        logic res_now;
        logic res_div;
        logic div_busy;
        logic out_free;
    } rgbs_status_t;

    function automatic logic [FIELD_BITS-1:0] dim_color(input logic [FIELD_BITS-1:0] color);
        logic [13:0] red_p;
        logic [13:0] green_p;
        logic [13:0] blue_p;
        red_p   = 14'(color[15:11]) * 14'(DIV3_MUL);
        green_p = 14'(color[10:5]) * 14'(DIV3_MUL);
        blue_p  = 14'(color[4:0]) * 14'(DIV3_MUL);
        return {5'(red_p >> DIV3_SHIFT), 6'(green_p >> DIV3_SHIFT), 5'(blue_p >> DIV3_SHIFT)};
    endfunction

endpackage

// ===== rtl/rgb565_image_blit_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// rgb565_image_blit_scaler_unit
// Parses an RGB565 image byte stream and issues one screen write per pixel,
// either copied at the window origin or scaled into the window.
//
// Usage:
//   Input channel in_valid/in_ready carries image_byte and start_of_image,
//   one file byte per transaction. Bytes 2-5 hold width and height, then
//   pixels follow as big-endian byte pairs.
//   Output channel out_valid/out_ready carries screen_x, screen_y,
//   pixel_color, write_valid and image_done, one transaction per pixel
//   (plus one for an empty image).
//   Header bytes, first pixel bytes and bytes after the image are taken
//   in ST_IDLE; the last header byte of an empty image also passes ST_EMIT.
//   A second pixel byte passes ST_EMIT in plain and off modes; in the
//   scaled modes it first passes the bit-serial divider, which runs once
//   for the column and once for the row.
//   The output register holds one result; a new byte is taken while it
//   waits. When the receiver stalls and a second result is ready, input
//   stops until the output register frees up.
//   Reset clears the parser, the output valid flag and the configuration
//   (limits to all ones, plain mode). Write configuration only when idle.
// ----------------------------------------------------------------------------
module rgb565_image_blit_scaler_unit #(
    parameter int COORD_BITS = rgbs_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rgbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rgbs_pkg::FIELD_BITS-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rgbs_pkg::BYTE_BITS-1:0]      image_byte,
    input  logic                                start_of_image,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rgbs_pkg::FIELD_BITS-1:0]     screen_x,
    output logic [rgbs_pkg::FIELD_BITS-1:0]     screen_y,
    output logic [rgbs_pkg::FIELD_BITS-1:0]     pixel_color,
    output logic                                write_valid,
    output logic                                image_done
);

    rgbs_pkg::rgbs_cmd_t    cmd;
    rgbs_pkg::rgbs_status_t status;

    rgbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rgbs_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .image_byte     (image_byte),
        .start_of_image (start_of_image),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .screen_x       (screen_x),
        .screen_y       (screen_y),
        .pixel_color    (pixel_color),
        .write_valid    (write_valid),
        .image_done     (image_done)
    );

endmodule

// ===== rtl/rgbs_div.sv =====
// ----------------------------------------------------------------------------
// rgbs_div
// Restoring divider, one quotient bit per cycle. The upper part of the
// dividend must be below the divisor, so the quotient fits QUOT_BITS bits.
// ----------------------------------------------------------------------------
module rgbs_div #(
    parameter int QUOT_BITS = rgbs_pkg::COORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [rgbs_pkg::FIELD_BITS+QUOT_BITS-1:0] dividend,
    input  logic [rgbs_pkg::FIELD_BITS-1:0]           divisor,
    output logic                                      busy,
    output logic [QUOT_BITS-1:0]                      quotient
);

    localparam int FB       = rgbs_pkg::FIELD_BITS;
    localparam int CNT_BITS = $clog2(QUOT_BITS);

    logic                 busy_reg;
    logic                 busy_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;
    logic [FB-1:0]        rem_reg;
    logic [FB-1:0]        rem_next;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [QUOT_BITS-1:0] quot_next;
    logic [FB-1:0]        divisor_reg;
    logic [FB:0]          trial;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[QUOT_BITS-1]};
        fits      = (trial >= {1'b0, divisor_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(QUOT_BITS - 1);
            rem_next  = dividend[FB+QUOT_BITS-1:QUOT_BITS];
            quot_next = dividend[QUOT_BITS-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? FB'(trial - {1'b0, divisor_reg}) : trial[FB-1:0];
            quot_next = {quot_reg[QUOT_BITS-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

// ===== rtl/rgbs_datapath.sv =====
// ----------------------------------------------------------------------------
// rgbs_datapath
// Configuration registers, image header parser, pixel counters, scale
// multiplier and divider, result formatting and the output register.
// ----------------------------------------------------------------------------
module rgbs_datapath #(
    parameter int COORD_BITS = rgbs_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rgbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rgbs_pkg::FIELD_BITS-1:0]     cfg_data,
    input  logic [rgbs_pkg::BYTE_BITS-1:0]      image_byte,
    input  logic                                start_of_image,
    input  rgbs_pkg::rgbs_cmd_t                 cmd,
    output rgbs_pkg::rgbs_status_t              status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [rgbs_pkg::FIELD_BITS-1:0]     screen_x,
    output logic [rgbs_pkg::FIELD_BITS-1:0]     screen_y,
    output logic [rgbs_pkg::FIELD_BITS-1:0]     pixel_color,
    output logic                                write_valid,
    output logic                                image_done
);

    localparam int FB = rgbs_pkg::FIELD_BITS;
    localparam int CB = COORD_BITS;

    // configuration
    logic [CB-1:0]          origin_x_reg;
    logic [CB-1:0]          origin_y_reg;
    logic [CB-1:0]          limit_x_reg;
    logic [CB-1:0]          limit_y_reg;
    rgbs_pkg::draw_mode_t   draw_mode_reg;

    // parser state
    logic [2:0]    header_pos_reg;
    logic [2:0]    header_pos_next;
    logic [FB-1:0] image_width_reg;
    logic [FB-1:0] image_width_next;
    logic [FB-1:0] image_height_reg;
    logic [FB-1:0] image_height_next;
    logic [FB-1:0] column_count_reg;
    logic [FB-1:0] column_count_next;
    logic [FB-1:0] row_count_reg;
    logic [FB-1:0] row_count_next;
    logic [7:0]    high_byte_reg;
    logic [7:0]    high_byte_next;
    logic          byte_phase_reg;
    logic          byte_phase_next;

    logic [2:0]    hp_eff;
    logic [FB-1:0] col_inc;
    logic [FB-1:0] row_inc;
    logic          empty_res;
    logic          pixel_res;
    logic          last_pixel;
    logic          scaled_mode;

    // pending transaction
    logic [FB-1:0] pend_col_reg;
    logic [FB-1:0] pend_row_reg;
    logic [FB-1:0] pend_color_reg;
    logic          pend_done_reg;
    logic          pend_empty_reg;
    logic [CB-1:0] qx_reg;

    // scale unit
    logic [CB-1:0]    span_x;
    logic [CB-1:0]    span_y;
    logic [FB-1:0]    mul_a;
    logic [CB-1:0]    mul_b;
    logic [FB+CB-1:0] product;
    logic [FB-1:0]    div_divisor;
    logic             div_busy;
    logic [CB-1:0]    div_quotient;

    // result
    logic [CB-1:0] res_x;
    logic [CB-1:0] res_y;
    logic [FB-1:0] res_color;
    logic          res_valid;

    logic          out_valid_reg;
    logic [FB-1:0] screen_x_reg;
    logic [FB-1:0] screen_y_reg;
    logic [FB-1:0] pixel_color_reg;
    logic          write_valid_reg;
    logic          image_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            limit_x_reg   <= '1;
            limit_y_reg   <= '1;
            draw_mode_reg <= rgbs_pkg::MODE_PLAIN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rgbs_pkg::REG_ORIGIN_X:  origin_x_reg  <= cfg_data[CB-1:0];
                rgbs_pkg::REG_ORIGIN_Y:  origin_y_reg  <= cfg_data[CB-1:0];
                rgbs_pkg::REG_LIMIT_X:   limit_x_reg   <= cfg_data[CB-1:0];
                rgbs_pkg::REG_LIMIT_Y:   limit_y_reg   <= cfg_data[CB-1:0];
                rgbs_pkg::REG_DRAW_MODE: draw_mode_reg <= rgbs_pkg::draw_mode_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        hp_eff            = start_of_image ? rgbs_pkg::HP_BYTE0 : header_pos_reg;
        header_pos_next   = header_pos_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        high_byte_next    = high_byte_reg;
        byte_phase_next   = byte_phase_reg;
        col_inc           = column_count_reg + FB'(1);
        row_inc           = row_count_reg + FB'(1);
        empty_res         = 1'b0;
        pixel_res         = 1'b0;
        last_pixel        = 1'b0;

        case (hp_eff)
            rgbs_pkg::HP_WIDTH_HI:  image_width_next[15:8]  = image_byte;
            rgbs_pkg::HP_WIDTH_LO:  image_width_next[7:0]   = image_byte;
            rgbs_pkg::HP_HEIGHT_HI: image_height_next[15:8] = image_byte;
            rgbs_pkg::HP_HEIGHT_LO: image_height_next[7:0]  = image_byte;
            default: ;
        endcase

        if (hp_eff < rgbs_pkg::HP_PIXELS)
        begin
            header_pos_next = hp_eff + 3'd1;
            if (hp_eff == rgbs_pkg::HP_HEIGHT_LO)
            begin
                column_count_next = '0;
                row_count_next    = '0;
                high_byte_next    = '0;
                byte_phase_next   = 1'b0;
                if (image_width_next == '0 || image_height_next == '0)
                begin
                    header_pos_next = rgbs_pkg::HP_DONE;
                    empty_res       = 1'b1;
                end
            end
        end
        else if (hp_eff == rgbs_pkg::HP_PIXELS)
        begin
            if (!byte_phase_reg)
            begin
                high_byte_next  = image_byte;
                byte_phase_next = 1'b1;
            end
            else
            begin
                byte_phase_next = 1'b0;
                pixel_res       = 1'b1;
                if (col_inc >= image_width_reg)
                begin
                    column_count_next = '0;
                    row_count_next    = row_inc;
                    if (row_inc >= image_height_reg)
                    begin
                        last_pixel      = 1'b1;
                        header_pos_next = rgbs_pkg::HP_DONE;
                    end
                end
                else
                begin
                    column_count_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg   <= rgbs_pkg::HP_BYTE0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            high_byte_reg    <= '0;
            byte_phase_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            header_pos_reg   <= header_pos_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            high_byte_reg    <= high_byte_next;
            byte_phase_reg   <= byte_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && pixel_res)
        begin
            pend_col_reg   <= column_count_reg;
            pend_row_reg   <= row_count_reg;
            pend_color_reg <= {high_byte_reg, image_byte};
            pend_done_reg  <= last_pixel;
            pend_empty_reg <= 1'b0;
        end
        else if (cmd.accept && empty_res)
        begin
            pend_done_reg  <= 1'b1;
            pend_empty_reg <= 1'b1;
        end
        if (cmd.save_x)
        begin
            qx_reg <= div_quotient;
        end
    end

    assign scaled_mode = draw_mode_reg inside {rgbs_pkg::MODE_SCALED, rgbs_pkg::MODE_DIM};

    // target = origin + floor(index * span / length)
    assign span_x      = (limit_x_reg >= origin_x_reg) ? limit_x_reg - origin_x_reg : '0;
    assign span_y      = (limit_y_reg >= origin_y_reg) ? limit_y_reg - origin_y_reg : '0;
    assign mul_a       = cmd.div_sel_y ? pend_row_reg : pend_col_reg;
    assign mul_b       = cmd.div_sel_y ? span_y : span_x;
    assign product     = (FB+CB)'(mul_a) * (FB+CB)'(mul_b);
    assign div_divisor = cmd.div_sel_y ? image_height_reg : image_width_reg;

    rgbs_div #(
        .QUOT_BITS (CB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_comb
    begin
        res_x     = '0;
        res_y     = '0;
        res_color = pend_color_reg;
        case (draw_mode_reg)
            rgbs_pkg::MODE_PLAIN:
            begin
                res_x = pend_col_reg[CB-1:0] + origin_x_reg;
                res_y = pend_row_reg[CB-1:0] + origin_y_reg;
            end
            rgbs_pkg::MODE_SCALED:
            begin
                res_x = origin_x_reg + qx_reg;
                res_y = origin_y_reg + div_quotient;
            end
            rgbs_pkg::MODE_DIM:
            begin
                res_x     = origin_x_reg + qx_reg;
                res_y     = origin_y_reg + div_quotient;
                res_color = rgbs_pkg::dim_color(pend_color_reg);
            end
            rgbs_pkg::MODE_OFF: ;
            default: ;
        endcase
        res_valid = (draw_mode_reg != rgbs_pkg::MODE_OFF)
                    && (res_x <= limit_x_reg) && (res_y <= limit_y_reg);
        // empty image: done marker only
        if (pend_empty_reg)
        begin
            res_x     = '0;
            res_y     = '0;
            res_color = '0;
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            screen_x_reg    <= FB'(res_x);
            screen_y_reg    <= FB'(res_y);
            pixel_color_reg <= res_color;
            write_valid_reg <= res_valid;
            image_done_reg  <= pend_done_reg;
        end
    end

    assign status.res_now  = cmd.accept ? (empty_res || (pixel_res && !scaled_mode)) : 1'b0;
    assign status.res_div  = cmd.accept ? (pixel_res && scaled_mode) : 1'b0;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign screen_x    = screen_x_reg;
    assign screen_y    = screen_y_reg;
    assign pixel_color = pixel_color_reg;
    assign write_valid = write_valid_reg;
    assign image_done  = image_done_reg;

endmodule

// ===== rtl/rgbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgbs_ctrl
// Controller: accepts bytes, sequences the two scale divisions of a pixel
// and hands each result to the output register.
// ----------------------------------------------------------------------------
module rgbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rgbs_pkg::rgbs_status_t status,
    output rgbs_pkg::rgbs_cmd_t    cmd
);

    rgbs_pkg::rgbs_state_t state_reg;
    rgbs_pkg::rgbs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            rgbs_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (status.res_div)
                begin
                    state_next = rgbs_pkg::ST_DIV_X_GO;
                end
                else if (status.res_now)
                begin
                    state_next = rgbs_pkg::ST_EMIT;
                end
            end
            rgbs_pkg::ST_DIV_X_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = rgbs_pkg::ST_DIV_X_WAIT;
            end
            rgbs_pkg::ST_DIV_X_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.save_x    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_y = 1'b1;
                    state_next    = rgbs_pkg::ST_DIV_Y_WAIT;
                end
            end
            rgbs_pkg::ST_DIV_Y_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = rgbs_pkg::ST_EMIT;
                end
            end
            rgbs_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rgbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rgbs_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> status.div_busy)
        else $error("divider not busy after start");

    a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !in_ready)
        else $error("input taken during a division");

    a_scaled_pixel_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.res_div) |=> cmd.div_start)
        else $error("scaled pixel did not start a division");
`endif

endmodule
